/* rtl/binary_min_heap_queue_assert.svh */
// ----------------------------------------------------------------------------
// binary_min_heap_queue_assert.svh
// Assertion macros used by the heap queue checker.
// ----------------------------------------------------------------------------
`ifndef BINARY_MIN_HEAP_QUEUE_ASSERT_SVH
`define BINARY_MIN_HEAP_QUEUE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define BMHQ_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bmhq: same-cycle property failed");

// consequent checked in the cycle after the antecedent
`define BMHQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bmhq: next-cycle property failed");

`endif

/* rtl/bmhq_pkg.sv */
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared constants, codes and types of the binary min-heap queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

   // heap geometry
   localparam int CAPACITY  = 31;
   localparam int ADDR_W    = $clog2(CAPACITY + 1);
   localparam int MEM_DEPTH = 1 << ADDR_W;
   localparam int KEY_W     = 32;
   localparam int FUNC_W    = 3;
   localparam int STAT_W    = 2;
   localparam int POS_W     = 5;
   localparam int CNT_W     = 5;

   // operation codes
   localparam logic [FUNC_W-1:0] FN_INSERT   = 3'd0;
   localparam logic [FUNC_W-1:0] FN_EXTRACT  = 3'd1;
   localparam logic [FUNC_W-1:0] FN_DECREASE = 3'd2;
   localparam logic [FUNC_W-1:0] FN_INCREASE = 3'd3;
   localparam logic [FUNC_W-1:0] FN_PEEK     = 3'd4;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UP,
      S_DOWN,
      S_EXTRACT,
      S_PEEK
   } state_type;

   // controller to memory: one write port, two read ports
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [KEY_W-1:0]  wdata;
      logic [ADDR_W-1:0] raddr0;
      logic [ADDR_W-1:0] raddr1;
   } mem_req_type;

   // finished request, registered onto the response ports
   typedef struct packed {
      logic              valid;
      logic [KEY_W-1:0]  min_value;
      logic [STAT_W-1:0] status;
      logic [ADDR_W-1:0] count;
   } done_type;

   // signed key order
   function automatic logic key_less(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
      return $signed(a) < $signed(b);
   endfunction

endpackage

/* rtl/bmhq_ram.sv */
// ----------------------------------------------------------------------------
// bmhq_ram
// Heap key store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module bmhq_ram (
   input  logic                       clock,
   input  bmhq_pkg::mem_req_type      mem_req,
   output logic [bmhq_pkg::KEY_W-1:0] rd0,
   output logic [bmhq_pkg::KEY_W-1:0] rd1
);

   logic [bmhq_pkg::KEY_W-1:0] mem_ff [bmhq_pkg::MEM_DEPTH];
   logic [bmhq_pkg::KEY_W-1:0] rd0_ff;
   logic [bmhq_pkg::KEY_W-1:0] rd1_ff;

   // write port
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.waddr] <= mem_req.wdata;
      end
   end

   // read ports, registered read data
   always_ff @(posedge clock) begin
      rd0_ff <= mem_ff[mem_req.raddr0];
      rd1_ff <= mem_ff[mem_req.raddr1];
   end

   assign rd0 = rd0_ff;
   assign rd1 = rd1_ff;

endmodule

/* rtl/bmhq_ctrl.sv */
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Request decode and sift sequencer. The moving key is held in a register;
// each tree level reads the neighbor(s), compares and writes one entry.
// ----------------------------------------------------------------------------
module bmhq_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [bmhq_pkg::FUNC_W-1:0] func,
   input  logic [bmhq_pkg::KEY_W-1:0]  key,
   input  logic [bmhq_pkg::POS_W-1:0]  position,
   input  logic [bmhq_pkg::KEY_W-1:0]  rd0,
   input  logic [bmhq_pkg::KEY_W-1:0]  rd1,
   output bmhq_pkg::mem_req_type       mem_req,
   output bmhq_pkg::done_type          done,
   output logic                        busy
);

   localparam int AW = bmhq_pkg::ADDR_W;

   bmhq_pkg::state_type state_ff, state_in;
   logic [AW-1:0]              count_ff, count_in;
   logic [AW-1:0]              pos_ff, pos_in;
   logic [bmhq_pkg::KEY_W-1:0] key_ff, key_in;
   logic [bmhq_pkg::KEY_W-1:0] minv_ff, minv_in;

   logic          is_empty;
   logic          is_full;
   logic          range_bad;
   logic [AW-1:0] req_pos;
   logic [AW-1:0] ins_pos;
   logic [AW:0]   req_left;
   logic [AW-1:0] parent;
   logic          up_move;
   logic [AW:0]   left_w;
   logic [AW:0]   right_w;
   logic          has_left;
   logic          has_right;
   logic          l_less;
   logic          r_less;
   logic [bmhq_pkg::KEY_W-1:0] r_ref;
   logic          dn_move;
   logic [AW-1:0] dn_best;
   logic [bmhq_pkg::KEY_W-1:0] dn_best_v;
   logic [AW:0]   best_left;

   // request checks
   always_comb begin
      is_empty  = (count_ff == '0);
      is_full   = (count_ff == AW'(bmhq_pkg::CAPACITY));
      range_bad = (position == '0) || (int'(position) > int'(count_ff));
      req_pos   = AW'(position);
      ins_pos   = count_ff + AW'(1);
      req_left  = {req_pos, 1'b0};
   end

   // sift-up step: rd0 holds the parent key
   always_comb begin
      parent  = pos_ff >> 1;
      up_move = (pos_ff != AW'(1)) && bmhq_pkg::key_less(key_ff, rd0);
   end

   // sift-down step: rd0/rd1 hold the children, left wins ties
   always_comb begin
      left_w    = {pos_ff, 1'b0};
      right_w   = left_w + (AW+1)'(1);
      has_left  = (left_w <= {1'b0, count_ff});
      has_right = (right_w <= {1'b0, count_ff});
      l_less    = bmhq_pkg::key_less(rd0, key_ff);
      r_ref     = l_less ? rd0 : key_ff;
      r_less    = has_right && bmhq_pkg::key_less(rd1, r_ref);
      dn_move   = has_left && (l_less || r_less);
      dn_best   = r_less ? right_w[AW-1:0] : left_w[AW-1:0];
      dn_best_v = r_less ? rd1 : rd0;
      best_left = {dn_best, 1'b0};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bmhq_pkg::S_IDLE: begin
            if (accept) begin
               case (func)
                  bmhq_pkg::FN_INSERT:
                     state_in = is_full ? bmhq_pkg::S_IDLE : bmhq_pkg::S_UP;
                  bmhq_pkg::FN_EXTRACT:
                     state_in = is_empty ? bmhq_pkg::S_IDLE : bmhq_pkg::S_EXTRACT;
                  bmhq_pkg::FN_DECREASE:
                     state_in = range_bad ? bmhq_pkg::S_IDLE : bmhq_pkg::S_UP;
                  bmhq_pkg::FN_INCREASE:
                     state_in = range_bad ? bmhq_pkg::S_IDLE : bmhq_pkg::S_DOWN;
                  bmhq_pkg::FN_PEEK:
                     state_in = is_empty ? bmhq_pkg::S_IDLE : bmhq_pkg::S_PEEK;
                  default:
                     state_in = bmhq_pkg::S_IDLE;
               endcase
            end
         end
         bmhq_pkg::S_UP:      state_in = up_move ? bmhq_pkg::S_UP : bmhq_pkg::S_IDLE;
         bmhq_pkg::S_DOWN:    state_in = dn_move ? bmhq_pkg::S_DOWN : bmhq_pkg::S_IDLE;
         bmhq_pkg::S_EXTRACT: state_in = bmhq_pkg::S_DOWN;
         bmhq_pkg::S_PEEK:    state_in = bmhq_pkg::S_IDLE;
         default:             state_in = bmhq_pkg::S_IDLE;
      endcase
   end

   // datapath, memory port and completion
   always_comb begin
      count_in       = count_ff;
      pos_in         = pos_ff;
      key_in         = key_ff;
      minv_in        = minv_ff;
      mem_req        = '0;
      done           = '0;
      done.count     = count_ff;
      done.min_value = minv_ff;
      case (state_ff)
         bmhq_pkg::S_IDLE: begin
            if (accept) begin
               minv_in        = '0;
               key_in         = key;
               done.min_value = '0;
               case (func)
                  bmhq_pkg::FN_INSERT: begin
                     if (is_full) begin
                        done.valid  = 1'b1;
                        done.status = bmhq_pkg::STAT_FULL;
                     end else begin
                        count_in       = ins_pos;
                        pos_in         = ins_pos;
                        mem_req.raddr0 = ins_pos >> 1;
                     end
                  end
                  bmhq_pkg::FN_EXTRACT: begin
                     if (is_empty) begin
                        done.valid  = 1'b1;
                        done.status = bmhq_pkg::STAT_EMPTY;
                     end else begin
                        mem_req.raddr0 = AW'(1);
                        mem_req.raddr1 = count_ff;
                     end
                  end
                  bmhq_pkg::FN_DECREASE: begin
                     if (range_bad) begin
                        done.valid  = 1'b1;
                        done.status = bmhq_pkg::STAT_RANGE;
                     end else begin
                        pos_in         = req_pos;
                        mem_req.raddr0 = req_pos >> 1;
                     end
                  end
                  bmhq_pkg::FN_INCREASE: begin
                     if (range_bad) begin
                        done.valid  = 1'b1;
                        done.status = bmhq_pkg::STAT_RANGE;
                     end else begin
                        pos_in         = req_pos;
                        mem_req.raddr0 = req_left[AW-1:0];
                        mem_req.raddr1 = req_left[AW-1:0] + AW'(1);
                     end
                  end
                  bmhq_pkg::FN_PEEK: begin
                     if (is_empty) begin
                        done.valid  = 1'b1;
                        done.status = bmhq_pkg::STAT_EMPTY;
                     end else begin
                        mem_req.raddr0 = AW'(1);
                     end
                  end
                  default: begin
                     done.valid  = 1'b1;
                     done.status = bmhq_pkg::STAT_OK;
                  end
               endcase
            end
         end
         bmhq_pkg::S_UP: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = pos_ff;
            if (up_move) begin
               // parent moves down into the hole
               mem_req.wdata  = rd0;
               pos_in         = parent;
               mem_req.raddr0 = parent >> 1;
            end else begin
               mem_req.wdata = key_ff;
               done.valid    = 1'b1;
               done.status   = bmhq_pkg::STAT_OK;
            end
         end
         bmhq_pkg::S_DOWN: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = pos_ff;
            if (dn_move) begin
               // smaller child moves up into the hole
               mem_req.wdata  = dn_best_v;
               pos_in         = dn_best;
               mem_req.raddr0 = best_left[AW-1:0];
               mem_req.raddr1 = best_left[AW-1:0] + AW'(1);
            end else begin
               mem_req.wdata = key_ff;
               done.valid    = 1'b1;
               done.status   = bmhq_pkg::STAT_OK;
            end
         end
         bmhq_pkg::S_EXTRACT: begin
            // rd0 is the root, rd1 the last entry which becomes the moving key
            minv_in        = rd0;
            key_in         = rd1;
            count_in       = count_ff - AW'(1);
            pos_in         = AW'(1);
            mem_req.raddr0 = AW'(2);
            mem_req.raddr1 = AW'(3);
         end
         bmhq_pkg::S_PEEK: begin
            done.valid     = 1'b1;
            done.status    = bmhq_pkg::STAT_OK;
            done.min_value = rd0;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bmhq_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      key_ff  <= key_in;
      minv_ff <= minv_in;
   end

   assign busy = (state_ff != bmhq_pkg::S_IDLE);

endmodule

/* rtl/binary_min_heap_queue.sv */
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Binary min-heap priority queue: insert, extract-min, decrease-key,
// increase-key and peek on a key store held in a two-read, one-write memory.
//
//   channel    ports                                       handshake
//   request    req_func, req_key, req_position             start && !busy
//   response   rsp_min_value, rsp_status, rsp_count         rsp_valid, 1 cycle
//
// At each tree level of a sift, the neighbor keys arrive from the memory's
// read ports, are compared with the moving key and one entry is written back
// while the next level is read. Rejected requests and unused codes do not
// make the block busy. The response follows in the cycle after the last busy
// cycle. Synchronous reset empties the heap; the store itself is not cleared.
// The receiver cannot stall the response.
// ----------------------------------------------------------------------------
module binary_min_heap_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [bmhq_pkg::FUNC_W-1:0] req_func,
   input  logic [bmhq_pkg::KEY_W-1:0]  req_key,
   input  logic [bmhq_pkg::POS_W-1:0]  req_position,
   output logic                        rsp_valid,
   output logic [bmhq_pkg::KEY_W-1:0]  rsp_min_value,
   output logic [bmhq_pkg::STAT_W-1:0] rsp_status,
   output logic [bmhq_pkg::CNT_W-1:0]  rsp_count
);

   bmhq_pkg::mem_req_type      mem_req;
   bmhq_pkg::done_type         done;
   logic [bmhq_pkg::KEY_W-1:0] rd0;
   logic [bmhq_pkg::KEY_W-1:0] rd1;
   logic                       accept;

   logic                        rsp_valid_ff;
   logic [bmhq_pkg::KEY_W-1:0]  rsp_min_value_ff;
   logic [bmhq_pkg::STAT_W-1:0] rsp_status_ff;
   logic [bmhq_pkg::CNT_W-1:0]  rsp_count_ff;

   assign accept = start && !busy;

   bmhq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .func     (req_func),
      .key      (req_key),
      .position (req_position),
      .rd0      (rd0),
      .rd1      (rd1),
      .mem_req  (mem_req),
      .done     (done),
      .busy     (busy)
   );

   bmhq_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd0     (rd0),
      .rd1     (rd1)
   );

   // response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= done.valid;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (done.valid) begin
         rsp_min_value_ff <= done.min_value;
         rsp_status_ff    <= done.status;
         rsp_count_ff     <= bmhq_pkg::CNT_W'(done.count);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_min_value = rsp_min_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_count     = rsp_count_ff;

endmodule

/* rtl/bmhq_checker.sv */
// ----------------------------------------------------------------------------
// bmhq_checker
// Port-level checks of the heap queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "binary_min_heap_queue_assert.svh"

module bmhq_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_valid,
   input logic [bmhq_pkg::KEY_W-1:0]  rsp_min_value,
   input logic [bmhq_pkg::STAT_W-1:0] rsp_status,
   input logic [bmhq_pkg::CNT_W-1:0]  rsp_count
);

   logic rsp_full;
   logic rsp_empty;
   logic full_ok;
   logic empty_ok;

   // status decode of the response
   assign rsp_full  = rsp_valid && (rsp_status == bmhq_pkg::STAT_FULL);
   assign rsp_empty = rsp_valid && (rsp_status == bmhq_pkg::STAT_EMPTY);
   assign full_ok   = (rsp_count == bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY));
   assign empty_ok  = (rsp_count == '0) && (rsp_min_value == '0);

   // a response only appears once the sequencer is back to idle
   `BMHQ_ASSERT_SAME(a_rsp_when_idle, rsp_valid, !busy)

   // busy only rises after a request was presented
   `BMHQ_ASSERT_SAME(a_busy_after_start, $rose(busy), $past(start))

   // full status implies a heap at capacity
   `BMHQ_ASSERT_SAME(a_full_count, rsp_full, full_ok)

   // empty status implies no entries and a zero key
   `BMHQ_ASSERT_SAME(a_empty_zero, rsp_empty, empty_ok)

endmodule

bind binary_min_heap_queue bmhq_checker u_bmhq_checker (.*);
